// ===== rtl/lcd_pkg.sv =====
package lcd_pkg;

    localparam int ACT_W = 3;
    localparam int ID_W = 64;
    localparam int CNT_W = 16;
    localparam int CHATS_W = 5;
    localparam int TOT_W = 32;

    localparam int ENTRIES_DEFAULT = 16;
    localparam logic [CHATS_W-1:0] CHAT_LIMIT_RESET = 5'd16;

    localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PROBE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POPULATE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_APPEND = 3'd3;
    localparam logic [ACT_W-1:0] ACT_INVALIDATE = 3'd4;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd5;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic signed [ID_W-1:0] chat_id;
        logic signed [ID_W-1:0] span_oldest_id;
        logic signed [ID_W-1:0] span_newest_id;
        logic [CNT_W-1:0] stored_msgs;
        logic signed [ID_W-1:0] message_id;
    } lcd_req_t;

    typedef struct packed {
        logic hit;
        logic signed [ID_W-1:0] entry_oldest_id;
        logic signed [ID_W-1:0] entry_newest_id;
        logic [CNT_W-1:0] entry_count;
        logic appended;
        logic evicted;
        logic signed [ID_W-1:0] victim_chat_id;
        logic [CHATS_W-1:0] chats_in_use;
        logic [TOT_W-1:0] hits_total;
        logic [TOT_W-1:0] misses_total;
    } lcd_rsp_t;

endpackage

// ===== rtl/lcd_req_reg.sv =====
module lcd_req_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lcd_pkg::lcd_req_t in_req,
    input  logic              advance,
    output logic              req_valid,
    output lcd_pkg::lcd_req_t req
);
    import lcd_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    lcd_req_t  req_reg;
    logic      take;

    assign in_ready = !valid_reg || advance;
    assign take = in_valid && in_ready;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg <= in_req;
        end
    end

    assign req_valid = valid_reg;
    assign req = req_reg;

endmodule

// ===== rtl/lcd_dir_core.sv =====
module lcd_dir_core #(
    parameter int ENTRIES = lcd_pkg::ENTRIES_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [lcd_pkg::CHATS_W-1:0]  cfg_wdata,
    input  logic                         fire,
    input  lcd_pkg::lcd_req_t            req,
    output lcd_pkg::lcd_rsp_t            rsp
);
    import lcd_pkg::*;

    localparam int RW = $clog2(ENTRIES);
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int CW = (OW > CHATS_W) ? OW : CHATS_W;
    localparam logic [CW-1:0] ENT_C = CW'(ENTRIES);
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    logic [ID_W-1:0]    key_reg    [ENTRIES];
    logic [ID_W-1:0]    oldest_reg [ENTRIES];
    logic [ID_W-1:0]    newest_reg [ENTRIES];
    logic [CNT_W-1:0]   cnt_reg    [ENTRIES];
    logic [RW-1:0]      rank_reg   [ENTRIES];
    logic [RW-1:0]      rank_next  [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [OW-1:0]      occ_reg;
    logic [OW-1:0]      occ_next;
    logic [TOT_W-1:0]   hits_reg;
    logic [TOT_W-1:0]   hits_next;
    logic [TOT_W-1:0]   misses_reg;
    logic [TOT_W-1:0]   misses_next;
    logic [CHATS_W-1:0] chat_limit_reg;

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] victim_oh;
    logic [ENTRIES-1:0] valid_after;
    logic [ENTRIES-1:0] free_oh;
    logic               hit;
    logic               have_free;
    logic [RW-1:0]      hit_rank;
    logic [ID_W-1:0]    hit_oldest;
    logic [ID_W-1:0]    hit_newest;
    logic [CNT_W-1:0]   hit_cnt;
    logic [CNT_W-1:0]   cnt_inc;
    logic [ID_W-1:0]    victim_key;
    logic [OW-1:0]      occ_m1;
    logic [CW-1:0]      mc_ext;
    logic [CW-1:0]      limit_ext;
    logic [OW-1:0]      limit;
    logic [CW-1:0]      occ_wide;

    logic is_lookup;
    logic is_pop;
    logic is_app;
    logic is_inv;
    logic is_clear;
    logic pop_ok;
    logic do_evict;
    logic ins;
    logic upd_hit;
    logic app_ok;
    logic do_promote;
    logic do_remove;

    assign occ_m1 = occ_reg - 1'b1;
    assign mc_ext = CW'(chat_limit_reg);

    always_comb
    begin
        if (mc_ext == '0)
        begin
            limit_ext = CW'(1);
        end
        else if (mc_ext > ENT_C)
        begin
            limit_ext = ENT_C;
        end
        else
        begin
            limit_ext = mc_ext;
        end
    end

    assign limit = OW'(limit_ext);

    always_comb
    begin
        hit_rank = '0;
        hit_oldest = '0;
        hit_newest = '0;
        hit_cnt = '0;
        victim_key = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == req.chat_id);
            victim_oh[i] = valid_reg[i] && (OW'(rank_reg[i]) == occ_m1);
            if (match[i])
            begin
                hit_rank = hit_rank | rank_reg[i];
                hit_oldest = hit_oldest | oldest_reg[i];
                hit_newest = hit_newest | newest_reg[i];
                hit_cnt = hit_cnt | cnt_reg[i];
            end
            if (victim_oh[i])
            begin
                victim_key = victim_key | key_reg[i];
            end
        end
    end

    assign hit = |match;
    assign cnt_inc = (hit_cnt == CNT_MAX) ? hit_cnt : hit_cnt + 1'b1;

    always_comb
    begin
        is_lookup = 1'b0;
        is_pop = 1'b0;
        is_app = 1'b0;
        is_inv = 1'b0;
        is_clear = 1'b0;
        case (req.action)
            ACT_LOOKUP:     is_lookup = 1'b1;
            ACT_POPULATE:   is_pop = 1'b1;
            ACT_APPEND:     is_app = 1'b1;
            ACT_INVALIDATE: is_inv = 1'b1;
            ACT_CLEAR:      is_clear = 1'b1;
            default:        ;
        endcase
    end

    assign pop_ok = is_pop && (req.stored_msgs != '0);
    assign do_evict = pop_ok && !hit && (occ_reg >= limit) && (|victim_oh);
    assign valid_after = valid_reg & ~(do_evict ? victim_oh : '0);
    assign free_oh = ~valid_after & (valid_after + 1'b1);
    assign have_free = |free_oh;
    assign ins = pop_ok && !hit && have_free;
    assign upd_hit = pop_ok && hit;
    assign app_ok = is_app && hit && ($signed(req.message_id) > $signed(hit_newest));
    assign do_promote = (is_lookup && hit) || upd_hit || app_ok;
    assign do_remove = is_inv && hit;

    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (is_clear)
            begin
                valid_next[i] = 1'b0;
                rank_next[i] = '0;
            end
            else if (do_remove)
            begin
                if (match[i])
                begin
                    valid_next[i] = 1'b0;
                end
                else if (valid_reg[i] && (rank_reg[i] > hit_rank))
                begin
                    rank_next[i] = rank_reg[i] - 1'b1;
                end
            end
            else if (do_promote)
            begin
                if (match[i])
                begin
                    rank_next[i] = '0;
                end
                else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
            end
            else if (ins)
            begin
                if (free_oh[i])
                begin
                    valid_next[i] = 1'b1;
                    rank_next[i] = '0;
                end
                else if (valid_after[i])
                begin
                    rank_next[i] = rank_reg[i] + 1'b1;
                end
                else
                begin
                    valid_next[i] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        occ_next = occ_reg;
        hits_next = hits_reg;
        misses_next = misses_reg;
        if (is_clear)
        begin
            occ_next = '0;
        end
        else if (do_remove)
        begin
            occ_next = occ_m1;
        end
        else if (ins && !do_evict)
        begin
            occ_next = occ_reg + 1'b1;
        end
        if (is_lookup)
        begin
            if (hit)
            begin
                hits_next = hits_reg + 1'b1;
            end
            else
            begin
                misses_next = misses_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg <= '0;
            hits_reg <= '0;
            misses_reg <= '0;
            chat_limit_reg <= CHAT_LIMIT_RESET;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                chat_limit_reg <= cfg_wdata;
            end
            if (fire)
            begin
                valid_reg <= valid_next;
                occ_reg <= occ_next;
                hits_reg <= hits_next;
                misses_reg <= misses_next;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    rank_reg[i] <= rank_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (fire && ins && free_oh[i])
            begin
                key_reg[i] <= req.chat_id;
                oldest_reg[i] <= req.span_oldest_id;
                newest_reg[i] <= req.span_newest_id;
                cnt_reg[i] <= req.stored_msgs;
            end
            else if (fire && upd_hit && match[i])
            begin
                oldest_reg[i] <= req.span_oldest_id;
                newest_reg[i] <= req.span_newest_id;
                cnt_reg[i] <= req.stored_msgs;
            end
            else if (fire && app_ok && match[i])
            begin
                newest_reg[i] <= req.message_id;
                cnt_reg[i] <= cnt_inc;
            end
        end
    end

    assign occ_wide = CW'(occ_next);

    always_comb
    begin
        rsp.hit = hit;
        rsp.appended = app_ok;
        rsp.evicted = do_evict;
        rsp.victim_chat_id = do_evict ? victim_key : '0;
        rsp.chats_in_use = occ_wide[CHATS_W-1:0];
        rsp.hits_total = hits_next;
        rsp.misses_total = misses_next;
        if (is_clear || do_remove || !(hit || ins))
        begin
            rsp.entry_oldest_id = '0;
            rsp.entry_newest_id = '0;
            rsp.entry_count = '0;
        end
        else if (ins || upd_hit)
        begin
            rsp.entry_oldest_id = req.span_oldest_id;
            rsp.entry_newest_id = req.span_newest_id;
            rsp.entry_count = req.stored_msgs;
        end
        else if (app_ok)
        begin
            rsp.entry_oldest_id = hit_oldest;
            rsp.entry_newest_id = req.message_id;
            rsp.entry_count = cnt_inc;
        end
        else
        begin
            rsp.entry_oldest_id = hit_oldest;
            rsp.entry_newest_id = hit_newest;
            rsp.entry_count = hit_cnt;
        end
    end

endmodule

// ===== rtl/lcd_rsp_reg.sv =====
module lcd_rsp_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  lcd_pkg::lcd_rsp_t rsp_in,
    output logic              free,
    output logic              out_valid,
    input  logic              out_ready,
    output lcd_pkg::lcd_rsp_t rsp
);
    import lcd_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    lcd_rsp_t rsp_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= rsp_in;
        end
    end

    assign out_valid = valid_reg;
    assign rsp = rsp_reg;

endmodule

// ===== rtl/lru_chat_directory.sv =====
// A request accepted into the request register goes through the directory once the result
// register is free; its result is then registered there and out_valid rises.
// Throughput: one request per cycle while results are taken, set by the combinational key compare and recency
// update of the directory between the request register and the result register.
// Reset (rst_n low, asynchronous) empties the directory, zeroes both counters and sets
// the chat limit to 16.
module lru_chat_directory #(
    parameter int ENTRIES = lcd_pkg::ENTRIES_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lcd_pkg::CHATS_W-1:0]        cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [lcd_pkg::ACT_W-1:0]          action,
    input  logic signed [lcd_pkg::ID_W-1:0]    chat_id,
    input  logic signed [lcd_pkg::ID_W-1:0]    span_oldest_id,
    input  logic signed [lcd_pkg::ID_W-1:0]    span_newest_id,
    input  logic [lcd_pkg::CNT_W-1:0]          stored_msgs,
    input  logic signed [lcd_pkg::ID_W-1:0]    message_id,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               hit,
    output logic signed [lcd_pkg::ID_W-1:0]    entry_oldest_id,
    output logic signed [lcd_pkg::ID_W-1:0]    entry_newest_id,
    output logic [lcd_pkg::CNT_W-1:0]          entry_count,
    output logic                               appended,
    output logic                               evicted,
    output logic signed [lcd_pkg::ID_W-1:0]    victim_chat_id,
    output logic [lcd_pkg::CHATS_W-1:0]        chats_in_use,
    output logic [lcd_pkg::TOT_W-1:0]          hits_total,
    output logic [lcd_pkg::TOT_W-1:0]          misses_total
);
    import lcd_pkg::*;

    lcd_req_t in_req;
    lcd_req_t req;
    lcd_rsp_t core_rsp;
    lcd_rsp_t rsp;
    logic     req_valid;
    logic     rsp_free;
    logic     advance;

    assign in_req.action = action;
    assign in_req.chat_id = chat_id;
    assign in_req.span_oldest_id = span_oldest_id;
    assign in_req.span_newest_id = span_newest_id;
    assign in_req.stored_msgs = stored_msgs;
    assign in_req.message_id = message_id;

    assign advance = req_valid && rsp_free;

    lcd_req_reg u_req (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_req    (in_req),
        .advance   (advance),
        .req_valid (req_valid),
        .req       (req)
    );

    lcd_dir_core #(
        .ENTRIES (ENTRIES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (advance),
        .req       (req),
        .rsp       (core_rsp)
    );

    lcd_rsp_reg u_rsp (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .rsp_in    (core_rsp),
        .free      (rsp_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rsp       (rsp)
    );

    assign hit = rsp.hit;
    assign entry_oldest_id = rsp.entry_oldest_id;
    assign entry_newest_id = rsp.entry_newest_id;
    assign entry_count = rsp.entry_count;
    assign appended = rsp.appended;
    assign evicted = rsp.evicted;
    assign victim_chat_id = rsp.victim_chat_id;
    assign chats_in_use = rsp.chats_in_use;
    assign hits_total = rsp.hits_total;
    assign misses_total = rsp.misses_total;

endmodule

// ===== rtl/lcd_checker.sv =====
module lcd_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               cfg_we,
    input logic [lcd_pkg::CHATS_W-1:0]        cfg_wdata,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic [lcd_pkg::ACT_W-1:0]          action,
    input logic signed [lcd_pkg::ID_W-1:0]    chat_id,
    input logic signed [lcd_pkg::ID_W-1:0]    span_oldest_id,
    input logic signed [lcd_pkg::ID_W-1:0]    span_newest_id,
    input logic [lcd_pkg::CNT_W-1:0]          stored_msgs,
    input logic signed [lcd_pkg::ID_W-1:0]    message_id,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic                               hit,
    input logic signed [lcd_pkg::ID_W-1:0]    entry_oldest_id,
    input logic signed [lcd_pkg::ID_W-1:0]    entry_newest_id,
    input logic [lcd_pkg::CNT_W-1:0]          entry_count,
    input logic                               appended,
    input logic                               evicted,
    input logic signed [lcd_pkg::ID_W-1:0]    victim_chat_id,
    input logic [lcd_pkg::CHATS_W-1:0]        chats_in_use,
    input logic [lcd_pkg::TOT_W-1:0]          hits_total,
    input logic [lcd_pkg::TOT_W-1:0]          misses_total
);

    // A result that is not taken must stay put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hits_total)
            && $stable(misses_total) && $stable(entry_count))
        else $error("result changed while stalled");

    // Eviction only happens when the key was absent.
    a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> !hit)
        else $error("eviction reported on a hit");

    // An accepted append needs a present key.
    a_append_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && appended |-> hit && !evicted)
        else $error("append accepted without a hit");

    // Without an eviction there is no victim key.
    a_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted |-> victim_chat_id == '0)
        else $error("victim key shown without an eviction");

endmodule

bind lru_chat_directory lcd_checker u_lcd_checker (.*);
